@@ sv/smf_pkg.sv @@
// Shared constants and types for the sliding median filter.
package smf_pkg;

   localparam int WINDOW   = 10;
   localparam int TAG_W    = $clog2(WINDOW);
   localparam int SAMPLE_W = 16;
   localparam int SUM_W    = SAMPLE_W + 1;
   localparam int MID_LO   = (WINDOW - 1) / 2;
   localparam int MID_HI   = WINDOW / 2;

   // One slot of the sorted chain: value, ring slot it came from, and
   // whether it is <= the incoming sample.
   typedef struct packed {
      logic [SAMPLE_W-1:0] val;
      logic [TAG_W-1:0]    tag;
      logic                le;
   } cell_type;

endpackage

@@ sv/smf_cell.sv @@
// One cell of the sorted window chain: holds a sample and its ring slot tag.
module smf_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          shift_en,
   input  logic [smf_pkg::SAMPLE_W-1:0]  new_val,
   input  logic [smf_pkg::TAG_W-1:0]     new_tag,
   input  logic [smf_pkg::TAG_W-1:0]     reset_tag,
   input  smf_pkg::cell_type             prev_cell,
   input  smf_pkg::cell_type             next_cell,
   input  logic                          evict_in,
   output logic                          evict_out,
   output smf_pkg::cell_type             cell_out
);

   logic [smf_pkg::SAMPLE_W-1:0] val_ff, val_in;
   logic [smf_pkg::TAG_W-1:0]    tag_ff, tag_in;
   logic                         own_le;
   smf_pkg::cell_type            own_cell, here_cell, prev_sel;

   assign own_le   = (val_ff <= new_val);
   assign own_cell = '{val: val_ff, tag: tag_ff, le: own_le};
   assign cell_out = own_cell;

   // evict_in: evicted entry sits somewhere before this cell.
   assign evict_out = evict_in | (tag_ff == new_tag);

   // View of the chain with the evicted entry removed.
   assign here_cell = evict_out ? next_cell : own_cell;
   assign prev_sel  = evict_in  ? own_cell  : prev_cell;

   always_comb begin
      if (here_cell.le) begin
         val_in = here_cell.val;
         tag_in = here_cell.tag;
      end else if (prev_sel.le) begin
         val_in = new_val;
         tag_in = new_tag;
      end else begin
         val_in = prev_sel.val;
         tag_in = prev_sel.tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= '0;
         tag_ff <= reset_tag;
      end else if (shift_en) begin
         val_ff <= val_in;
         tag_ff <= tag_in;
      end
   end

endmodule

@@ sv/sliding_median_filter_core.sv @@
// Top level of the sliding-window median filter (sorted cell chain).
//
// Usage:
//  - req channel: one 16-bit unsigned sample per transaction
//    (req_valid/req_ready/req_sample).
//  - rsp channel: one result per request transaction, in order:
//    rsp_median_sum is the sum of the two middle sorted window values
//    (twice the median), rsp_valid_res is set once the window has been
//    written through once. Before that, median_sum reads zero.
//  - The window lives in a chain of WINDOW cells kept in sorted order.
//    Each accepted sample evicts the cell tagged with the current ring
//    slot and is inserted at its sorted place, in the same update.
//  - Result path: the chain update and the pending flag are registered,
//    then the middle-pair sum is registered once the output is free.
//  - Throughput: one transaction per cycle while rsp_ready stays high; the
//    single pending stage and the output register set this figure.
//  - Receiver stall: the output register holds; one more sample can be
//    taken into the chain, then req_ready drops until the output drains.
//  - Reset (synchronous, active high): window cleared to zero, ring slot
//    and fill flag cleared, no result pending.
module sliding_median_filter_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [smf_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [smf_pkg::SUM_W-1:0]     rsp_median_sum,
   output logic                          rsp_valid_res
);

   localparam logic [smf_pkg::TAG_W-1:0] LastSlot = smf_pkg::TAG_W'(smf_pkg::WINDOW - 1);

   smf_pkg::cell_type cells [smf_pkg::WINDOW];
   logic              evict [smf_pkg::WINDOW+1];

   logic                      req_fire, load_out;
   logic                      pend_ff, pend_in;
   logic                      filled_ff, filled_in;
   logic [smf_pkg::TAG_W-1:0] wpos_ff, wpos_in;
   logic                      out_vld_ff, out_vld_in;
   logic [smf_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic                      res_ff, res_in;
   logic [smf_pkg::SUM_W-1:0] mid_sum;

   // A result is pending in the chain; move it out when the output is free.
   assign load_out  = pend_ff & (~out_vld_ff | rsp_ready);
   assign req_ready = ~pend_ff | load_out;
   assign req_fire  = req_valid & req_ready;

   // Boundary ties: nothing before cell 0 (insert there if needed), nothing
   // past the last cell (never pulled in).
   localparam smf_pkg::cell_type HeadTie = '{val: '0, tag: '0, le: 1'b1};
   localparam smf_pkg::cell_type TailTie = '{val: '0, tag: '0, le: 1'b0};

   assign evict[0] = 1'b0;

   for (genvar i = 0; i < smf_pkg::WINDOW; i++) begin : g_chain
      smf_pkg::cell_type prev_c, next_c;
      if (i == 0) begin : g_head
         assign prev_c = HeadTie;
      end else begin : g_prev
         assign prev_c = cells[i-1];
      end
      if (i == smf_pkg::WINDOW - 1) begin : g_tail
         assign next_c = TailTie;
      end else begin : g_next
         assign next_c = cells[i+1];
      end

      smf_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (req_fire),
         .new_val   (req_sample),
         .new_tag   (wpos_ff),
         .reset_tag (smf_pkg::TAG_W'(i)),
         .prev_cell (prev_c),
         .next_cell (next_c),
         .evict_in  (evict[i]),
         .evict_out (evict[i+1]),
         .cell_out  (cells[i])
      );
   end

   // Ring slot and fill flag track the write position of the window.
   always_comb begin
      wpos_in   = wpos_ff;
      filled_in = filled_ff;
      if (req_fire) begin
         if (wpos_ff == LastSlot) begin
            wpos_in   = '0;
            filled_in = 1'b1;
         end else begin
            wpos_in = wpos_ff + 1'b1;
         end
      end
   end

   assign mid_sum = {1'b0, cells[smf_pkg::MID_LO].val}
                  + {1'b0, cells[smf_pkg::MID_HI].val};

   always_comb begin
      pend_in    = pend_ff;
      out_vld_in = out_vld_ff;
      sum_in     = sum_ff;
      res_in     = res_ff;
      if (load_out) begin
         pend_in    = 1'b0;
         out_vld_in = 1'b1;
         sum_in     = filled_ff ? mid_sum : '0;
         res_in     = filled_ff;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
      if (req_fire) begin
         pend_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff    <= 1'b0;
         out_vld_ff <= 1'b0;
         filled_ff  <= 1'b0;
         wpos_ff    <= '0;
      end else begin
         pend_ff    <= pend_in;
         out_vld_ff <= out_vld_in;
         filled_ff  <= filled_in;
         wpos_ff    <= wpos_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      res_ff <= res_in;
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_median_sum = sum_ff;
   assign rsp_valid_res  = res_ff;

endmodule

@@ sv/smf_checker.sv @@
// Port-level checks for the sliding median filter, bound to the top level.
module smf_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [smf_pkg::SUM_W-1:0]     rsp_median_sum,
   input logic                          rsp_valid_res
);

   logic seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready && rsp_valid_res) begin
         seen_ff <= 1'b1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_median_sum))
      else $error("rsp dropped or changed while stalled");

   a_fill_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_ff |-> rsp_valid_res)
      else $error("valid_res fell after window filled");

   a_zero_before_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> rsp_median_sum == '0)
      else $error("nonzero median before window filled");

   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   a_ready_after_drain: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req stalled with empty output");

endmodule

bind sliding_median_filter_core smf_checker u_smf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_median_sum (rsp_median_sum),
   .rsp_valid_res  (rsp_valid_res)
);

@@ verif/tb.sv @@
// Self-checking testbench for sliding_median_filter_core.
`timescale 1ns / 1ps

// One predicted result: twice the window median, and whether the window has filled.
typedef struct packed {
   logic [smf_pkg::SUM_W-1:0] median_sum;
   logic                      valid_res;
} median_result_type;

// Kinds of random sample streams. Each one stresses a different part of the sort.
typedef enum int {
   PAT_UNIFORM,   // full 16-bit range, reaches every bit
   PAT_CLUSTER,   // narrow band, many ties
   PAT_EXTREME,   // hugs 0 and full scale
   PAT_RAMP,      // stride walk that wraps, so order keeps shifting
   PAT_SPIKE      // one repeated level with random outliers
} sample_pattern_type;

// Tracks the filter window. Each accepted sample queues its expected result,
// and each result from the block is checked against the oldest one.
class median_tracker;
   localparam int DEPTH   = smf_pkg::WINDOW;
   localparam int LOW_MID = (DEPTH - 1) / 2;
   localparam int HIGH_MID = DEPTH / 2;

   logic [smf_pkg::SAMPLE_W-1:0] ring [DEPTH];
   int unsigned                  next_slot;
   bit                           window_full;
   logic [smf_pkg::SUM_W-1:0]    last_median_sum;
   median_result_type            due_medians[$];
   int unsigned                  failures;

   function new();
      foreach (ring[i]) ring[i] = '0;
      next_slot       = 0;
      window_full     = 1'b0;
      last_median_sum = '0;
      failures        = 0;
   endfunction

   function int unsigned outstanding();
      return due_medians.size();
   endfunction

   function void note_sample(logic [smf_pkg::SAMPLE_W-1:0] new_sample);
      logic [smf_pkg::SAMPLE_W-1:0] ordered [DEPTH];
      logic [smf_pkg::SAMPLE_W-1:0] key;
      median_result_type            result;
      int                           i;
      int                           j;
      ring[next_slot] = new_sample;
      if (next_slot == DEPTH - 1) begin
         next_slot   = 0;
         window_full = 1'b1;
      end else begin
         next_slot = next_slot + 1;
      end
      // Insertion sort of a copy. The zero entries from reset take part too.
      ordered = ring;
      for (i = 1; i < DEPTH; i++) begin
         key = ordered[i];
         j   = i;
         while (j > 0 && ordered[j-1] > key) begin
            ordered[j] = ordered[j-1];
            j--;
         end
         ordered[j] = key;
      end
      // Until the window fills, the held sum (zero) is repeated.
      if (window_full)
         last_median_sum = {1'b0, ordered[LOW_MID]} + {1'b0, ordered[HIGH_MID]};
      result.median_sum = last_median_sum;
      result.valid_res  = window_full;
      due_medians.push_back(result);
   endfunction

   function void check_result(logic [smf_pkg::SUM_W-1:0] median_sum, logic valid_res);
      median_result_type want;
      if (due_medians.size() == 0) begin
         $error("unexpected result: median_sum %0d valid_res %0d", median_sum, valid_res);
         failures++;
         return;
      end
      want = due_medians.pop_front();
      if (median_sum !== want.median_sum) begin
         $error("median_sum: expected %0d, actual %0d", want.median_sum, median_sum);
         failures++;
      end
      if (valid_res !== want.valid_res) begin
         $error("valid_res: expected %0d, actual %0d", want.valid_res, valid_res);
         failures++;
      end
   endfunction
endclass

module tb;

   localparam int RESET_CYCLES     = 6;
   localparam int MAX_IDLE         = 16;
   localparam int SEGMENTS         = 30;
   localparam int SEGMENT_LEN      = 60;   // 30 x 60 random transactions
   localparam int DRAIN_SEGMENT    = 15;   // sender waits for an empty scoreboard here
   localparam int LONG_HOLD_AT     = 400;  // result count at which the sink stops
   localparam int LONG_HOLD_CYCLES = 100;
   localparam int SETTLE_CYCLES    = 8;
   localparam int QUIET_LIMIT      = 1000;

   // Directed stream. The first ten fill the window: the ninth result is still
   // invalid and the tenth is the first valid one. Next come ten full-scale
   // samples, which give the largest sum, then five low samples that push out half.
   localparam logic [smf_pkg::SAMPLE_W-1:0] DIRECTED_SAMPLES [25] = '{
      16'hFFFF, 16'h0000, 16'h8000, 16'h0001, 16'h7FFF,
      16'hFFFE, 16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00,
      16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
      16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
      16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000
   };

   logic                         clock      = 1'b0;
   logic                         reset      = 1'b1;
   logic                         req_valid  = 1'b0;
   logic                         req_ready;
   logic [smf_pkg::SAMPLE_W-1:0] req_sample = '0;
   logic                         rsp_valid;
   logic                         rsp_ready  = 1'b0;
   logic [smf_pkg::SUM_W-1:0]    rsp_median_sum;
   logic                         rsp_valid_res;

   // Set per segment: when high, neither side inserts idle cycles.
   bit                  no_idle = 1'b0;
   int unsigned         quiet_cycles = 0;
   median_tracker       tracker = new();

   always #5 clock = ~clock;

   sliding_median_filter_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_median_sum (rsp_median_sum),
      .rsp_valid_res  (rsp_valid_res)
   );

   // Offer one sample after a random gap and hold it until the block takes it.
   // If there is no gap, valid stays high and only the payload moves on, so
   // req_valid never gets two assignments in one step.
   task automatic send_sample(input logic [smf_pkg::SAMPLE_W-1:0] value);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and wait until every queued result has come back.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.outstanding() != 0);
   endtask

   // Monitor. Signals are sampled at the edge before the block's own updates
   // land, so the transactions seen here match what the block saw. The
   // watchdog is also here and restarts on any transaction.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_valid && req_ready)
            tracker.note_sample(req_sample);
         if (rsp_valid && rsp_ready)
            tracker.check_result(rsp_median_sum, rsp_valid_res);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("sliding_median_filter_core verification failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Result sink: a random stall before each result. Once, partway through,
   // it holds ready low for a long stretch. The sender keeps offering during
   // that time, so the chain fills and req_ready must drop.
   initial begin : result_sink
      int unsigned taken;
      int unsigned stall;
      bit          held_off;
      taken    = 0;
      held_off = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!held_off && taken == LONG_HOLD_AT) begin
            stall    = LONG_HOLD_CYCLES;
            held_off = 1'b1;
         end else begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
         end
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   // Stimulus and the final verdict.
   initial begin : stimulus
      sample_pattern_type           pattern;
      logic [smf_pkg::SAMPLE_W-1:0] base;
      logic [smf_pkg::SAMPLE_W-1:0] value;
      int unsigned                  stride;
      int unsigned                  seg;
      int unsigned                  n;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_SAMPLES[i])
         send_sample(DIRECTED_SAMPLES[i]);

      // Random part, in segments. Each segment has its own stream shape and
      // idle mode. About a quarter of them run with no idle cycles at all.
      for (seg = 0; seg < SEGMENTS; seg++) begin
         if (seg == DRAIN_SEGMENT)
            wait_for_drain();
         no_idle = ($urandom_range(0, 3) == 0);
         pattern = sample_pattern_type'($urandom_range(PAT_UNIFORM, PAT_SPIKE));
         base    = 16'($urandom);
         stride  = $urandom_range(1, 4000);
         for (n = 0; n < SEGMENT_LEN; n++) begin
            case (pattern)
               PAT_UNIFORM: begin
                  value = 16'($urandom);
               end
               PAT_CLUSTER: begin
                  value = 16'(base + $urandom_range(0, 7));
               end
               PAT_EXTREME: begin
                  if ($urandom_range(0, 1))
                     value = 16'(16'hFFFF - $urandom_range(0, 3));
                  else
                     value = 16'($urandom_range(0, 3));
               end
               PAT_RAMP: begin
                  value = 16'(base + n * stride);
               end
               default: begin
                  value = ($urandom_range(0, 3) != 0) ? base : 16'($urandom);
               end
            endcase
            send_sample(value);
         end
      end

      // Everything is sent. Wait for the last results, then wait out SETTLE_CYCLES
      // so that any extra result is caught.
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (tracker.failures == 0 && tracker.outstanding() == 0)
         $display("sliding_median_filter_core verification clean");
      else
         $display("sliding_median_filter_core verification failed");
      $finish;
   end

endmodule
